### hdl/wgfp_pkg.sv
// Shared constants for the wrap grid first-fit placer.
// Field widths, register indexes, operation codes and reset values.
// No dependencies.
package wgfp_pkg;

  localparam int unsigned OP_W   = 1;
  localparam int unsigned SPAN_W = 6;
  localparam int unsigned CW_W   = 12;   // cell width / height
  localparam int unsigned GAP_W  = 8;
  localparam int unsigned LIM_W  = 6;
  localparam int unsigned EXT_W  = 13;
  localparam int unsigned CFG_W  = 13;   // widest register
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned PIX_W  = 20;
  localparam int unsigned CELL_W = 7;
  localparam int unsigned USED_W = 8;
  localparam int unsigned XCNT_W = 6;

  localparam logic [PIX_W-1:0]  PIX_MAX  = '1;
  localparam logic [CELL_W-1:0] CELL_MAX = '1;
  localparam logic [USED_W-1:0] USED_MAX = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_ORIENT = 3'd0,
    REG_CELL_W = 3'd1,
    REG_CELL_H = 3'd2,
    REG_GAP    = 3'd3,
    REG_LIMIT  = 3'd4,
    REG_EXTENT = 3'd5
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_START = 1'b0,
    OP_PLACE = 1'b1
  } op_t;

  localparam logic [CW_W-1:0]  RST_CELL_W = 12'd100;
  localparam logic [CW_W-1:0]  RST_CELL_H = 12'd100;
  localparam logic [GAP_W-1:0] RST_GAP    = 8'd4;
  localparam logic [EXT_W-1:0] RST_EXTENT = 13'd200;

endpackage

### hdl/wrap_grid_first_fit_placer_unit.sv
// Top level of the wrap grid first-fit placer.
// Depends on wgfp_pkg, wgfp_occ_mem and wgfp_xdiv.
//
// Usage:
//  - Command channel: drive in_operation/in_row_span/in_col_span with start
//    high; the transfer happens on a rising edge where busy is low.
//  - One result per command: out_valid strobes for one cycle with the
//    out_* fields. The receiver cannot stall, so results are never held.
//  - cfg_we/cfg_index/cfg_data write a register at once; write only when
//    idle. Indexes beyond the list are ignored.
//  - Every command first derives the cross count with the subtract loop in
//    wgfp_xdiv.
//  - Start command: clears the occupancy memory one line a cycle, then
//    reports.
//  - Place command: for each candidate line the window lines are read from
//    the memory, ORed, then all cross-position windows are tested at once.
//    The lines of the first fitting window are then marked and the pixel
//    math is done. Search speed is set by the single memory read port.
//  - Reset: registers take reset values and the memory is swept clear
//    (busy high, no result).
module wrap_grid_first_fit_placer_unit #(
  parameter int unsigned GRID_LINES = 128,
  parameter int unsigned CROSS_MAX  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [wgfp_pkg::OP_W-1:0]        in_operation,
  input  logic [wgfp_pkg::SPAN_W-1:0]      in_row_span,
  input  logic [wgfp_pkg::SPAN_W-1:0]      in_col_span,
  output logic                             out_valid,
  output logic                             out_placed,
  output logic [wgfp_pkg::CELL_W-1:0]      out_cell_row,
  output logic [wgfp_pkg::CELL_W-1:0]      out_cell_col,
  output logic [wgfp_pkg::PIX_W-1:0]       out_pixel_x,
  output logic [wgfp_pkg::PIX_W-1:0]       out_pixel_y,
  output logic [wgfp_pkg::PIX_W-1:0]       out_pixel_w,
  output logic [wgfp_pkg::PIX_W-1:0]       out_pixel_h,
  output logic [wgfp_pkg::USED_W-1:0]      out_used_lines,
  output logic [wgfp_pkg::XCNT_W-1:0]      out_cross_count,
  input  logic                             cfg_we,
  input  logic [wgfp_pkg::IDX_W-1:0]       cfg_index,
  input  logic [wgfp_pkg::CFG_W-1:0]       cfg_data
);

  localparam int unsigned AW  = $clog2(GRID_LINES);
  localparam int unsigned LW  = $clog2(GRID_LINES + 1);   // holds GRID_LINES
  localparam int unsigned QW  = $clog2(CROSS_MAX + 1);
  localparam int unsigned PW  = $clog2(CROSS_MAX);
  localparam int unsigned VW  = (LW > QW) ? LW : QW;      // row/col value
  localparam int unsigned MW  = VW + wgfp_pkg::EXT_W;     // offset products
  localparam int unsigned SW  = wgfp_pkg::SPAN_W;
  localparam int unsigned ZW  = SW + wgfp_pkg::CW_W + 1;  // size sums
  localparam logic [LW-1:0] GRID_L   = LW'(GRID_LINES);
  localparam logic [AW-1:0] LAST_A   = AW'(GRID_LINES - 1);
  localparam logic [QW-1:0] XMAX     = QW'(CROSS_MAX);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_SETUP = 9'b000001000,
    S_RD    = 9'b000010000,
    S_EVAL  = 9'b000100000,
    S_MARK  = 9'b001000000,
    S_MATH  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  // configuration registers
  logic                          orient_r;
  logic [wgfp_pkg::CW_W-1:0]     cell_w_r, cell_h_r;
  logic [wgfp_pkg::GAP_W-1:0]    gap_r;
  logic [wgfp_pkg::LIM_W-1:0]    limit_r;
  logic [wgfp_pkg::EXT_W-1:0]    extent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= 1'b0;
      cell_w_r <= wgfp_pkg::RST_CELL_W;
      cell_h_r <= wgfp_pkg::RST_CELL_H;
      gap_r    <= wgfp_pkg::RST_GAP;
      limit_r  <= '0;
      extent_r <= wgfp_pkg::RST_EXTENT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wgfp_pkg::REG_ORIENT: orient_r <= cfg_data[0];
        wgfp_pkg::REG_CELL_W: cell_w_r <= cfg_data[wgfp_pkg::CW_W-1:0];
        wgfp_pkg::REG_CELL_H: cell_h_r <= cfg_data[wgfp_pkg::CW_W-1:0];
        wgfp_pkg::REG_GAP:    gap_r    <= cfg_data[wgfp_pkg::GAP_W-1:0];
        wgfp_pkg::REG_LIMIT:  limit_r  <= cfg_data[wgfp_pkg::LIM_W-1:0];
        wgfp_pkg::REG_EXTENT: extent_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and datapath registers
  state_t                state_r, state_nxt;
  logic                  op_r, op_nxt;
  logic [SW-1:0]         rs_r, rs_nxt, cs_r, cs_nxt;
  logic [SW-1:0]         lspan_r, lspan_nxt, xspan_r, xspan_nxt;
  logic [QW-1:0]         cross_r, cross_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [LW-1:0]         line_r, line_nxt;
  logic [SW:0]           iss_r, iss_nxt, rcv_r, rcv_nxt;
  logic                  rvld_r, rvld_nxt;
  logic [CROSS_MAX-1:0]  acc_r, acc_nxt;
  logic [CROSS_MAX-1:0]  mask_r, mask_nxt;
  logic [PW-1:0]         fpos_r, fpos_nxt;
  logic                  found_r, found_nxt;
  logic                  report_r, report_nxt;
  logic [wgfp_pkg::USED_W-1:0] used_r, used_nxt;

  // product registers
  logic [MW-1:0]         px_p_r, py_p_r;
  logic [ZW-1:0]         w_a_r, h_a_r;
  logic [SW+wgfp_pkg::GAP_W-1:0] w_b_r, h_b_r;
  logic [VW-1:0]         rowv_r, colv_r;

  // output registers
  logic                          ov_r;
  logic                          o_placed_r;
  logic [wgfp_pkg::CELL_W-1:0]   o_row_r, o_col_r;
  logic [wgfp_pkg::PIX_W-1:0]    o_x_r, o_y_r, o_w_r, o_h_r;
  logic [wgfp_pkg::USED_W-1:0]   o_used_r;
  logic [QW-1:0]                 o_cross_r;

  // memory port
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa, mem_ra;
  logic [CROSS_MAX-1:0]  mem_wd, mem_rd;

  wgfp_occ_mem #(.DEPTH(GRID_LINES), .WIDTH(CROSS_MAX)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  logic              div_go, div_done;
  logic [QW-1:0]     div_q;

  wgfp_xdiv #(.CROSS_MAX(CROSS_MAX)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .extent   (extent_r),
    .gap      (gap_r),
    .cell_len (orient_r ? cell_h_r : cell_w_r),
    .done     (div_done),
    .quot     (div_q)
  );

  // window test over all start positions of the ORed line set
  logic [CROSS_MAX-1:0] win_ok;
  logic                 win_any;
  logic [PW-1:0]        win_pos;
  logic [CROSS_MAX-1:0] win_mask;

  always_comb begin
    win_ok = '0;
    for (int p = 0; p < CROSS_MAX; p++) begin
      if ((QW+1)'(p) + (QW+1)'(xspan_r) <= (QW+1)'(cross_r)) begin
        win_ok[p] = 1'b1;
        for (int i = 0; i < CROSS_MAX; i++) begin
          if (i >= p && (SW+PW+1)'(i) < (SW+PW+1)'(p) + (SW+PW+1)'(xspan_r)
              && acc_r[i]) begin
            win_ok[p] = 1'b0;
          end
        end
      end
    end
    win_any = |win_ok;
    win_pos = '0;
    for (int p = CROSS_MAX - 1; p >= 0; p--) begin
      if (win_ok[p]) begin
        win_pos = PW'(p);
      end
    end
    win_mask = '0;
    for (int i = 0; i < CROSS_MAX; i++) begin
      if ((SW+PW+1)'(i) >= (SW+PW+1)'(win_pos) &&
          (SW+PW+1)'(i) < (SW+PW+1)'(win_pos) + (SW+PW+1)'(xspan_r)) begin
        win_mask[i] = 1'b1;
      end
    end
  end

  logic [SW-1:0]  rs_fix, cs_fix;
  logic [LW:0]    end_line;
  logic [LW:0]    next_end;
  logic [QW-1:0]  lim_sat;

  always_comb begin
    rs_fix   = (in_row_span == '0) ? SW'(1) : in_row_span;
    cs_fix   = (in_col_span == '0) ? SW'(1) : in_col_span;
    end_line = (LW+1)'(line_r) + (LW+1)'(lspan_r);
    next_end = end_line + 1'b1;
    lim_sat  = ((QW+1)'(limit_r) > (QW+1)'(XMAX)) ? XMAX : QW'(limit_r);
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    rs_nxt     = rs_r;
    cs_nxt     = cs_r;
    lspan_nxt  = lspan_r;
    xspan_nxt  = xspan_r;
    cross_nxt  = cross_r;
    clr_nxt    = clr_r;
    line_nxt   = line_r;
    iss_nxt    = iss_r;
    rcv_nxt    = rcv_r;
    rvld_nxt   = 1'b0;
    acc_nxt    = acc_r;
    mask_nxt   = mask_r;
    fpos_nxt   = fpos_r;
    found_nxt  = found_r;
    report_nxt = report_r;
    used_nxt   = used_r;
    div_go     = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = clr_r;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = AW'(line_r + LW'(iss_r));

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_A) begin
          clr_nxt   = '0;
          state_nxt = report_r ? S_MATH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          rs_nxt    = rs_fix;
          cs_nxt    = cs_fix;
          lspan_nxt = orient_r ? cs_fix : rs_fix;
          xspan_nxt = orient_r ? rs_fix : cs_fix;
          found_nxt = 1'b0;
          div_go    = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cross_nxt = (limit_r != '0) ? lim_sat : div_q;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        line_nxt = '0;
        iss_nxt  = '0;
        rcv_nxt  = '0;
        acc_nxt  = '0;
        if (op_r == wgfp_pkg::OP_START) begin
          used_nxt   = '0;
          report_nxt = 1'b1;
          state_nxt  = S_CLEAR;
        end else if ((QW+1)'(xspan_r) > (QW+1)'(cross_r) ||
                     (LW+1)'(lspan_r) > (LW+1)'(GRID_L)) begin
          state_nxt = S_MATH;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (iss_r < (SW+1)'(lspan_r)) begin
          mem_re   = 1'b1;
          rvld_nxt = 1'b1;
          iss_nxt  = iss_r + 1'b1;
        end
        if (rvld_r) begin
          acc_nxt = acc_r | mem_rd;
          rcv_nxt = rcv_r + 1'b1;
          if (rcv_r + 1'b1 == (SW+1)'(lspan_r)) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        iss_nxt = '0;
        rcv_nxt = '0;
        acc_nxt = '0;
        if (win_any) begin
          fpos_nxt  = win_pos;
          mask_nxt  = win_mask;
          state_nxt = S_MARK;
        end else if (next_end > (LW+1)'(GRID_L)) begin
          state_nxt = S_MATH;
        end else begin
          line_nxt  = line_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_MARK: begin
        // read-modify-write, one line a cycle, distinct lines in flight
        if (iss_r < (SW+1)'(lspan_r)) begin
          mem_re   = 1'b1;
          rvld_nxt = 1'b1;
          iss_nxt  = iss_r + 1'b1;
        end
        if (rvld_r) begin
          mem_we  = 1'b1;
          mem_wa  = AW'(line_r + LW'(rcv_r));
          mem_wd  = mem_rd | mask_r;
          rcv_nxt = rcv_r + 1'b1;
          if (rcv_r + 1'b1 == (SW+1)'(lspan_r)) begin
            found_nxt = 1'b1;
            if (end_line > (LW+1)'(wgfp_pkg::USED_MAX)) begin
              used_nxt = wgfp_pkg::USED_MAX;
            end else if (wgfp_pkg::USED_W'(end_line) > used_r) begin
              used_nxt = wgfp_pkg::USED_W'(end_line);
            end
            state_nxt = S_MATH;
          end
        end
      end
      S_MATH: begin
        report_nxt = 1'b0;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      report_r <= 1'b0;
      used_r   <= '0;
      rvld_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      report_r <= report_nxt;
      used_r   <= used_nxt;
      rvld_r   <= rvld_nxt;
      found_r  <= found_nxt;
    end
    op_r    <= op_nxt;
    rs_r    <= rs_nxt;
    cs_r    <= cs_nxt;
    lspan_r <= lspan_nxt;
    xspan_r <= xspan_nxt;
    cross_r <= cross_nxt;
    line_r  <= line_nxt;
    iss_r   <= iss_nxt;
    rcv_r   <= rcv_nxt;
    acc_r   <= acc_nxt;
    mask_r  <= mask_nxt;
    fpos_r  <= fpos_nxt;
  end

  // pixel products, registered before the sums
  logic [VW-1:0] rowv, colv;

  always_comb begin
    rowv = orient_r ? VW'(fpos_r) : VW'(line_r);
    colv = orient_r ? VW'(line_r) : VW'(fpos_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MATH) begin
      rowv_r <= rowv;
      colv_r <= colv;
      px_p_r <= MW'(colv) * MW'({1'b0, cell_w_r} + wgfp_pkg::EXT_W'(gap_r));
      py_p_r <= MW'(rowv) * MW'({1'b0, cell_h_r} + wgfp_pkg::EXT_W'(gap_r));
      w_a_r  <= ZW'(cs_r) * ZW'(cell_w_r);
      h_a_r  <= ZW'(rs_r) * ZW'(cell_h_r);
      w_b_r  <= (SW+wgfp_pkg::GAP_W)'(cs_r - 1'b1) * (SW+wgfp_pkg::GAP_W)'(gap_r);
      h_b_r  <= (SW+wgfp_pkg::GAP_W)'(rs_r - 1'b1) * (SW+wgfp_pkg::GAP_W)'(gap_r);
    end
  end

  function automatic logic [wgfp_pkg::PIX_W-1:0] sat_pix(input logic [MW:0] v);
    logic [wgfp_pkg::PIX_W-1:0] r;
    if (v > (MW+1)'(wgfp_pkg::PIX_MAX)) begin
      r = wgfp_pkg::PIX_MAX;
    end else begin
      r = wgfp_pkg::PIX_W'(v);
    end
    return r;
  endfunction

  function automatic logic [wgfp_pkg::CELL_W-1:0] sat_cell(input logic [VW-1:0] v);
    logic [wgfp_pkg::CELL_W-1:0] r;
    if ((VW+wgfp_pkg::CELL_W)'(v) > (VW+wgfp_pkg::CELL_W)'(wgfp_pkg::CELL_MAX)) begin
      r = wgfp_pkg::CELL_MAX;
    end else begin
      r = wgfp_pkg::CELL_W'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= (state_r == S_OUT);
    end
    if (state_r == S_OUT) begin
      o_placed_r <= found_r;
      o_used_r   <= used_r;
      o_cross_r  <= cross_r;
      if (found_r) begin
        o_row_r <= sat_cell(rowv_r);
        o_col_r <= sat_cell(colv_r);
        o_x_r   <= sat_pix((MW+1)'(px_p_r));
        o_y_r   <= sat_pix((MW+1)'(py_p_r));
        o_w_r   <= sat_pix((MW+1)'(w_a_r) + (MW+1)'(w_b_r));
        o_h_r   <= sat_pix((MW+1)'(h_a_r) + (MW+1)'(h_b_r));
      end else begin
        o_row_r <= '0;
        o_col_r <= '0;
        o_x_r   <= '0;
        o_y_r   <= '0;
        o_w_r   <= '0;
        o_h_r   <= '0;
      end
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_placed      = o_placed_r;
  assign out_cell_row    = o_row_r;
  assign out_cell_col    = o_col_r;
  assign out_pixel_x     = o_x_r;
  assign out_pixel_y     = o_y_r;
  assign out_pixel_w     = o_w_r;
  assign out_pixel_h     = o_h_r;
  assign out_used_lines  = o_used_r;
  assign out_cross_count = wgfp_pkg::XCNT_W'(o_cross_r);

endmodule

### hdl/wgfp_occ_mem.sv
// Occupancy store: one line of cross-position bits per grid line.
// One write port, one read port, read data registered. Uses no package.
module wgfp_occ_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/wgfp_xdiv.sv
// Cross count divider: repeated subtraction, stops at CROSS_MAX.
// Depends on wgfp_pkg for field widths.
module wgfp_xdiv #(
  parameter int unsigned CROSS_MAX = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [wgfp_pkg::EXT_W-1:0]        extent,
  input  logic [wgfp_pkg::GAP_W-1:0]        gap,
  input  logic [wgfp_pkg::CW_W-1:0]         cell_len,
  output logic                              done,
  output logic [$clog2(CROSS_MAX+1)-1:0]    quot
);

  localparam int unsigned QW = $clog2(CROSS_MAX + 1);
  localparam int unsigned RW = wgfp_pkg::EXT_W + 1;
  localparam logic [QW-1:0] QMAX = QW'(CROSS_MAX);

  logic          run_r, run_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] div_r, div_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    run_nxt  = run_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    if (go) begin
      run_nxt = 1'b1;
      rem_nxt = RW'(extent) + RW'(gap);
      div_nxt = RW'(cell_len) + RW'(gap);
      q_nxt   = '0;
    end else if (run_r) begin
      if (q_r < QMAX && rem_r >= div_r) begin
        rem_nxt = rem_r - div_r;
        q_nxt   = q_r + 1'b1;
      end else begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = (q_r == '0) ? QW'(1) : q_r;

endmodule
